// ----- rtl/ifrrb_pkg.sv -----
`default_nettype none
package ifrrb_pkg;

    localparam int BYTE_DEPTH  = 256;
    localparam int FRAME_SLOTS = 16;
    localparam int BYTE_AW     = $clog2(BYTE_DEPTH);
    localparam int SLOT_AW     = $clog2(FRAME_SLOTS);
    localparam int DATA_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int WAITING_W   = 4;

    typedef logic [BYTE_AW-1:0]   byte_ptr_t;
    typedef logic [SLOT_AW-1:0]   slot_ptr_t;
    typedef logic [SLOT_AW:0]     slot_cnt_t;
    typedef logic [DATA_W-1:0]    data_t;
    typedef logic [WAITING_W-1:0] waiting_t;

    typedef enum logic [1:0] {
        ACT_RX_BYTE = 2'd0,
        ACT_IDLE    = 2'd1,
        ACT_READ    = 2'd2,
        ACT_FLUSH   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE       = 3'd0,
        STS_DATA       = 3'd1,
        STS_NO_FRAME   = 3'd2,
        STS_EMPTY_SKIP = 3'd3,
        STS_MERGED     = 3'd4
    } status_t;

    typedef struct packed {
        logic      we;
        byte_ptr_t waddr;
        data_t     wdata;
        logic      re;
        byte_ptr_t raddr;
    } byte_req_t;

    typedef struct packed {
        logic      we;
        slot_ptr_t waddr;
        byte_ptr_t wdata;
        logic      re;
        slot_ptr_t raddr;
    } slot_req_t;

    function automatic byte_ptr_t byte_inc(input byte_ptr_t p);
        return (p == byte_ptr_t'(BYTE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic byte_ptr_t byte_dec(input byte_ptr_t p);
        return (p == '0) ? byte_ptr_t'(BYTE_DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic slot_ptr_t slot_inc(input slot_ptr_t p);
        return (p == slot_ptr_t'(FRAME_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic waiting_t slot_diff(input slot_ptr_t tail, input slot_ptr_t head);
        slot_cnt_t w;
        w = {1'b0, tail} + slot_cnt_t'(FRAME_SLOTS) - {1'b0, head};
        if (w >= slot_cnt_t'(FRAME_SLOTS)) begin
            w = w - slot_cnt_t'(FRAME_SLOTS);
        end
        return waiting_t'(w);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ifrrb_ram.sv -----
`default_nettype none
module ifrrb_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/ifrrb_ctrl.sv -----
`default_nettype none
module ifrrb_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_action,
    input  wire ifrrb_pkg::data_t            s_rx_byte,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [ifrrb_pkg::STATUS_W-1:0]   m_status,
    output ifrrb_pkg::data_t                 m_data_byte,
    output logic                             m_last_byte,
    output ifrrb_pkg::waiting_t              m_frames_waiting,
    output ifrrb_pkg::byte_req_t             byte_req,
    output ifrrb_pkg::slot_req_t             start_req,
    output ifrrb_pkg::slot_req_t             end_req,
    input  wire ifrrb_pkg::data_t            byte_rdata,
    input  wire ifrrb_pkg::byte_ptr_t        start_rdata,
    input  wire ifrrb_pkg::byte_ptr_t        end_rdata
);

    import ifrrb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DESC,
        ST_BYTE,
        ST_OUT
    } state_t;

    state_t    state_reg, state_next;
    byte_ptr_t wp_reg, wp_next;
    slot_ptr_t tail_reg, tail_next;
    slot_ptr_t head_reg, head_next;
    logic      start0_reg, start0_next;
    byte_ptr_t cur_start_reg, cur_start_next;
    status_t   res_status_reg, res_status_next;
    data_t     res_data_reg, res_data_next;
    logic      res_last_reg, res_last_next;
    logic      m_valid_reg, m_valid_next;
    status_t   m_status_reg, m_status_next;
    data_t     m_data_reg, m_data_next;
    logic      m_last_reg, m_last_next;
    waiting_t  m_frames_reg, m_frames_next;
    slot_ptr_t tail_inc;
    byte_ptr_t desc_start;

    assign tail_inc   = slot_inc(tail_reg);
    assign desc_start = (start0_reg && head_reg == '0) ? '0 : start_rdata;
    assign s_ready    = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        tail_next       = tail_reg;
        head_next       = head_reg;
        start0_next     = start0_reg;
        cur_start_next  = cur_start_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_last_next   = res_last_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_frames_next   = m_frames_reg;
        byte_req        = '0;
        start_req       = '0;
        end_req         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_status_next = STS_DONE;
                    res_data_next   = '0;
                    res_last_next   = 1'b0;
                    state_next      = ST_OUT;
                    case (s_action)
                        ACT_RX_BYTE: begin
                            byte_req.we    = 1'b1;
                            byte_req.waddr = wp_reg;
                            byte_req.wdata = s_rx_byte;
                            wp_next        = byte_inc(wp_reg);
                        end
                        ACT_IDLE: begin
                            end_req.we    = 1'b1;
                            end_req.waddr = tail_reg;
                            end_req.wdata = byte_dec(wp_reg);
                            if (tail_inc != head_reg) begin
                                tail_next       = tail_inc;
                                start_req.we    = 1'b1;
                                start_req.waddr = tail_inc;
                                start_req.wdata = wp_reg;
                                if (tail_inc == '0) begin
                                    start0_next = 1'b0;
                                end
                            end else begin
                                res_status_next = STS_MERGED;
                            end
                        end
                        ACT_READ: begin
                            if (head_reg == tail_reg) begin
                                res_status_next = STS_NO_FRAME;
                            end else begin
                                start_req.re    = 1'b1;
                                start_req.raddr = head_reg;
                                end_req.re      = 1'b1;
                                end_req.raddr   = head_reg;
                                state_next      = ST_DESC;
                            end
                        end
                        ACT_FLUSH: begin
                            wp_next     = '0;
                            tail_next   = '0;
                            head_next   = '0;
                            start0_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DESC: begin
                if (byte_inc(end_rdata) == desc_start) begin
                    head_next       = slot_inc(head_reg);
                    res_status_next = STS_EMPTY_SKIP;
                    state_next      = ST_OUT;
                end else begin
                    byte_req.re    = 1'b1;
                    byte_req.raddr = desc_start;
                    cur_start_next = desc_start;
                    res_last_next  = (desc_start == end_rdata);
                    state_next     = ST_BYTE;
                end
            end
            ST_BYTE: begin
                start_req.we    = 1'b1;
                start_req.waddr = head_reg;
                start_req.wdata = byte_inc(cur_start_reg);
                if (head_reg == '0) begin
                    start0_next = 1'b0;
                end
                if (res_last_reg) begin
                    head_next = slot_inc(head_reg);
                end
                res_data_next   = byte_rdata;
                res_status_next = STS_DATA;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_data_next   = res_data_reg;
                    m_last_next   = res_last_reg;
                    m_frames_next = slot_diff(tail_reg, head_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            tail_reg    <= '0;
            head_reg    <= '0;
            start0_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            tail_reg       <= tail_next;
            head_reg       <= head_next;
            start0_reg     <= start0_next;
            m_valid_reg    <= m_valid_next;
            cur_start_reg  <= cur_start_next;
            res_status_reg <= res_status_next;
            res_data_reg   <= res_data_next;
            res_last_reg   <= res_last_next;
            m_status_reg   <= m_status_next;
            m_data_reg     <= m_data_next;
            m_last_reg     <= m_last_next;
            m_frames_reg   <= m_frames_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_data_byte      = m_data_reg;
    assign m_last_byte      = m_last_reg;
    assign m_frames_waiting = m_frames_reg;

endmodule
`default_nettype wire

// ----- rtl/idle_framed_rx_ring_buffer.sv -----
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | s_action[1:0], s_rx_byte[7:0]
// m_      | out       | m_valid / m_ready  | m_status[2:0], m_data_byte[7:0],
//         |           |                    | m_last_byte, m_frames_waiting[3:0]
//
// Byte, idle, flush: straight to the result. A read does a descriptor read,
// then a byte read and start write-back, unless the frame is empty (skip).
// One item is in flight at a time; s_ready is high only between items.
// Synchronous active-low reset clears pointers; the RAMs are not cleared.
// A stalled m_ready holds the finished result and blocks the next item's end.
`default_nettype none
module idle_framed_rx_ring_buffer (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_action,
    input  wire logic [7:0]                s_rx_byte,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [ifrrb_pkg::STATUS_W-1:0] m_status,
    output logic [7:0]                     m_data_byte,
    output logic                           m_last_byte,
    output logic [3:0]                     m_frames_waiting
);

    import ifrrb_pkg::*;

    byte_req_t byte_req;
    slot_req_t start_req;
    slot_req_t end_req;
    data_t     byte_rdata;
    byte_ptr_t start_rdata;
    byte_ptr_t end_rdata;

    ifrrb_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_data_byte      (m_data_byte),
        .m_last_byte      (m_last_byte),
        .m_frames_waiting (m_frames_waiting),
        .byte_req         (byte_req),
        .start_req        (start_req),
        .end_req          (end_req),
        .byte_rdata       (byte_rdata),
        .start_rdata      (start_rdata),
        .end_rdata        (end_rdata)
    );

    ifrrb_ram #(.DEPTH(BYTE_DEPTH), .WIDTH(DATA_W)) u_byte_ram (
        .aclk  (aclk),
        .we    (byte_req.we),
        .waddr (byte_req.waddr),
        .wdata (byte_req.wdata),
        .re    (byte_req.re),
        .raddr (byte_req.raddr),
        .rdata (byte_rdata)
    );

    ifrrb_ram #(.DEPTH(FRAME_SLOTS), .WIDTH(BYTE_AW)) u_start_ram (
        .aclk  (aclk),
        .we    (start_req.we),
        .waddr (start_req.waddr),
        .wdata (start_req.wdata),
        .re    (start_req.re),
        .raddr (start_req.raddr),
        .rdata (start_rdata)
    );

    ifrrb_ram #(.DEPTH(FRAME_SLOTS), .WIDTH(BYTE_AW)) u_end_ram (
        .aclk  (aclk),
        .we    (end_req.we),
        .waddr (end_req.waddr),
        .wdata (end_req.wdata),
        .re    (end_req.re),
        .raddr (end_req.raddr),
        .rdata (end_rdata)
    );

endmodule
`default_nettype wire

// ----- rtl/ifrrb_checker.sv -----
`default_nettype none
module ifrrb_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [ifrrb_pkg::STATUS_W-1:0] m_status,
    input wire logic [7:0]                     m_data_byte,
    input wire logic                           m_last_byte,
    input wire logic [3:0]                     m_frames_waiting
);

    import ifrrb_pkg::*;

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_data_byte)
            && $stable(m_last_byte) && $stable(m_frames_waiting))
        else $error("stalled result changed");

    a_no_data_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STS_DATA |-> m_data_byte == '0 && !m_last_byte)
        else $error("data fields set without data status");

    a_no_frame_empty_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STS_NO_FRAME |-> m_frames_waiting == '0)
        else $error("no frame reported with frames queued");

    a_merged_queue_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STS_MERGED |-> m_frames_waiting == waiting_t'(FRAME_SLOTS - 1))
        else $error("merge reported with descriptor queue not full");

endmodule

bind idle_framed_rx_ring_buffer ifrrb_checker u_checker (.*);
`default_nettype wire
